[design/apq_pkg.sv]
// Shared types and codes for the array max-priority queue.
package apq_pkg;

  // Item operation codes
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_FINISH
  } apq_state_t;

  // Controller to datapath
  typedef struct packed {
    logic start;     // item accepted this cycle
    logic scan;      // compare one stored entry against the running maximum
    logic shift;     // move one entry down a place
    logic load_out;  // move the result into the output register
  } apq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic remove_go;   // incoming item is a remove on a non-empty queue
    logic scan_last;   // entry under compare is the last stored one
    logic shift_last;  // no entry left to move after this cycle
    logic out_free;    // output register can take a result
  } apq_sts_t;

endpackage

[design/apq_ctrl.sv]
// Sequencer for the array max-priority queue: accept, scan, shift, finish.
module apq_ctrl
  import apq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  apq_sts_t sts,
  output apq_cmd_t cmd
);

  apq_state_t state_r;
  apq_state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.remove_go ? ST_SCAN : ST_FINISH;
        end
      end
      ST_SCAN: begin
        if (sts.scan_last) begin
          state_nxt = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (sts.shift_last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Commands and input handshake
  always_comb begin
    in_stall     = (state_r != ST_IDLE);
    cmd.start    = (state_r == ST_IDLE) && in_valid;
    cmd.scan     = (state_r == ST_SCAN);
    cmd.shift    = (state_r == ST_SHIFT);
    cmd.load_out = (state_r == ST_FINISH) && sts.out_free;
  end

  // A result is loaded only once per accepted item
  a_load_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> (state_r == ST_IDLE))
    else $error("apq_ctrl: load did not return to idle");

  // Scan always hands over to shift, never straight to idle
  a_scan_to_shift: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |=> (state_r == ST_SCAN || state_r == ST_SHIFT))
    else $error("apq_ctrl: scan left without shifting");

  // Input is taken only when no item is in flight
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> (state_r != ST_IDLE))
    else $error("apq_ctrl: accepted item did not start work");

endmodule

[design/apq_datapath.sv]
// Entry store, running maximum, occupancy and output register of the queue.
module apq_datapath
  import apq_pkg::*;
#(
  parameter int DEPTH = 8,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CntW = $clog2(DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  apq_cmd_t                 cmd,
  output apq_sts_t                 sts,
  input  logic                     in_func,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic                     out_stall,
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] out_removed_value,
  output logic                     out_removed_valid,
  output logic                     out_rejected,
  output logic [CntW-1:0]          out_occupancy,
  output logic                     out_is_full,
  output logic                     out_is_empty
);

  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);
  localparam logic [CntW-1:0] OneCnt  = CntW'(1);

  logic [DATA_W-1:0]        mem [DEPTH];
  logic signed [DATA_W-1:0] rd_data_r;
  logic [AW-1:0]            rd_addr;
  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic [DATA_W-1:0]        wr_data;

  logic [CntW-1:0]          count_r, count_nxt;
  logic [CntW-1:0]          ptr_r, ptr_nxt;
  logic [AW-1:0]            best_idx_r, best_idx_nxt;
  logic signed [DATA_W-1:0] best_r, best_nxt;
  logic                     res_valid_r, res_rej_r;
  logic                     take;

  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_value_r;
  logic                     out_rm_valid_r, out_rej_r;
  logic [CntW-1:0]          out_occ_r;

  // Status back to the sequencer
  always_comb begin
    sts.remove_go  = (in_func == FUNC_REMOVE) && (count_r != '0);
    sts.scan_last  = (ptr_r == count_r - OneCnt);
    sts.shift_last = (ptr_r >= count_r - OneCnt);
    sts.out_free   = !out_valid_r || !out_stall;
  end

  // Running maximum: first entry always taken, ties keep the lower index
  assign take = (ptr_r == '0) || (rd_data_r > best_r);

  // Scan pointer, maximum and occupancy
  always_comb begin
    ptr_nxt      = ptr_r;
    best_idx_nxt = best_idx_r;
    best_nxt     = best_r;
    count_nxt    = count_r;
    wr_en        = 1'b0;
    wr_addr      = count_r[AW-1:0];
    wr_data      = in_value;
    if (cmd.start) begin
      ptr_nxt = '0;
      if (in_func == FUNC_INSERT && count_r != FullCnt) begin
        wr_en     = 1'b1;
        count_nxt = count_r + OneCnt;
      end
    end else if (cmd.scan) begin
      if (take) begin
        best_idx_nxt = ptr_r[AW-1:0];
        best_nxt     = rd_data_r;
      end
      // after the last compare, continue with the entry behind the maximum
      ptr_nxt = sts.scan_last ? (CntW'(best_idx_nxt) + OneCnt) : (ptr_r + OneCnt);
    end else if (cmd.shift) begin
      wr_en   = (ptr_r < count_r);
      wr_addr = AW'(ptr_r - OneCnt);
      wr_data = rd_data_r;
      ptr_nxt = ptr_r + OneCnt;
      if (sts.shift_last) begin
        count_nxt = count_r - OneCnt;
      end
    end
  end

  assign rd_addr = ptr_nxt[AW-1:0];

  // Entry store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ptr_r       <= '0;
      res_valid_r <= 1'b0;
      res_rej_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ptr_r   <= ptr_nxt;
      if (cmd.start) begin
        res_valid_r <= sts.remove_go;
        res_rej_r   <= (in_func == FUNC_REMOVE) ? (count_r == '0) : (count_r == FullCnt);
      end
      // hold while stalled, drop once taken
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    best_idx_r <= best_idx_nxt;
    best_r     <= best_nxt;
    if (cmd.load_out) begin
      out_value_r    <= res_valid_r ? best_r : '0;
      out_rm_valid_r <= res_valid_r;
      out_rej_r      <= res_rej_r;
      out_occ_r      <= count_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_removed_value = out_value_r;
  assign out_removed_valid = out_rm_valid_r;
  assign out_rejected      = out_rej_r;
  assign out_occupancy     = out_occ_r;
  assign out_is_full       = (out_occ_r == FullCnt);
  assign out_is_empty      = (out_occ_r == '0);

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FullCnt)
    else $error("apq_datapath: occupancy above depth");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan |-> (ptr_r < count_r))
    else $error("apq_datapath: scan beyond stored entries");

  a_shift_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.shift && wr_en) |-> (ptr_r != '0))
    else $error("apq_datapath: shift writes below entry zero");

  a_removed_not_rejected: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_rm_valid_r) |-> !out_rej_r)
    else $error("apq_datapath: result both removed and rejected");

endmodule

[design/array_priority_queue_max_core.sv]
// Array max-priority queue: top level joining sequencer and datapath.
//
// Usage: an item on the in_ channel is in_func (0 insert in_value, 1 remove
// the maximum) plus in_value. Each item yields exactly one item on the out_
// channel: the removed value (zero when nothing is removed), removed_valid,
// rejected (insert while full, remove while empty), and occupancy with
// full and empty flags as they stand after the item.
// Work is one item at a time; in_stall is high from acceptance until the
// result has entered the output register.
// An insert or a rejected item goes straight to the finish step. A remove
// scans the stored entries for the maximum, then shifts the entries behind
// it down one place; each step reads one entry per cycle through the single
// read port of the entry store. out_valid is registered: it rises in the
// cycle after the finish step loads the result.
// When out_stall holds a finished result, the next item is still accepted
// and worked on; it waits only to enter the output register.
// Reset (rst_n low, synchronous) empties the queue and drops any pending
// result; stored entries are not cleared.
module array_priority_queue_max_core
  import apq_pkg::*;
#(
  parameter int DEPTH = 8,
  localparam int CntW = $clog2(DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_func,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_removed_value,
  output logic                     out_removed_valid,
  output logic                     out_rejected,
  output logic [CntW-1:0]          out_occupancy,
  output logic                     out_is_full,
  output logic                     out_is_empty
);

  apq_cmd_t cmd;
  apq_sts_t sts;

  // Sequencer
  apq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Entry store and result path
  apq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_func           (in_func),
    .in_value          (in_value),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_removed_value (out_removed_value),
    .out_removed_valid (out_removed_valid),
    .out_rejected      (out_rejected),
    .out_occupancy     (out_occupancy),
    .out_is_full       (out_is_full),
    .out_is_empty      (out_is_empty)
  );

endmodule

[test/apq_checker.sv]
// Checker for the array max-priority queue: shadow queue, expected results, compare.
module apq_checker
  import apq_pkg::*;
#(
  parameter int DEPTH = 8,
  parameter int CntW  = $clog2(DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic                     in_func,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic signed [DATA_W-1:0] out_removed_value,
  input  logic                     out_removed_valid,
  input  logic                     out_rejected,
  input  logic [CntW-1:0]          out_occupancy,
  input  logic                     out_is_full,
  input  logic                     out_is_empty,
  output int                       fail_count,
  output int                       results_owed
);

  typedef struct packed {
    logic signed [DATA_W-1:0] removed_value;
    logic                     removed_valid;
    logic                     rejected;
    logic [CntW-1:0]          occupancy;
    logic                     is_full;
    logic                     is_empty;
  } apq_result_t;

  // Shadow copy of the queue contents
  logic signed [DATA_W-1:0] shadow_entries [DEPTH];
  int                       shadow_count;
  apq_result_t              predicted_results [$];

  initial begin
    fail_count   = 0;
    results_owed = 0;
    shadow_count = 0;
  end

  // Apply one item to the shadow queue and return the result it must produce
  function automatic apq_result_t queue_step(logic func, logic signed [DATA_W-1:0] value);
    apq_result_t res;
    int          best;
    int          i;
    res = '0;
    if (func == FUNC_INSERT) begin
      if (shadow_count >= DEPTH) begin
        res.rejected = 1'b1;
      end else begin
        shadow_entries[shadow_count] = value;
        shadow_count++;
      end
    end else if (shadow_count == 0) begin
      res.rejected = 1'b1;
    end else begin
      // Largest signed value wins, lowest index on ties
      best = 0;
      for (i = 1; i < shadow_count; i++) begin
        if (shadow_entries[i] > shadow_entries[best]) best = i;
      end
      res.removed_value = shadow_entries[best];
      res.removed_valid = 1'b1;
      // Close the gap, keep the order of the rest
      for (i = best; i + 1 < shadow_count; i++) begin
        shadow_entries[i] = shadow_entries[i + 1];
      end
      shadow_count--;
    end
    res.occupancy = shadow_count[CntW-1:0];
    res.is_full   = (shadow_count == DEPTH);
    res.is_empty  = (shadow_count == 0);
    return res;
  endfunction

  // Report a mismatch in detail for the first few, count the rest
  task automatic report_mismatch(string what, apq_result_t want, apq_result_t got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("apq_checker: %s at %0t", what, $realtime);
      $display("  expected value=%0d valid=%0b rej=%0b occ=%0d full=%0b empty=%0b",
               want.removed_value, want.removed_valid, want.rejected, want.occupancy,
               want.is_full, want.is_empty);
      $display("  actual   value=%0d valid=%0b rej=%0b occ=%0d full=%0b empty=%0b",
               got.removed_value, got.removed_valid, got.rejected, got.occupancy,
               got.is_full, got.is_empty);
    end
  endtask

  // Check the outgoing item first, then predict for the incoming one
  always @(posedge clk) begin
    apq_result_t got;
    apq_result_t want;
    if (!rst_n) begin
      shadow_count = 0;
      predicted_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got.removed_value = out_removed_value;
        got.removed_valid = out_removed_valid;
        got.rejected      = out_rejected;
        got.occupancy     = out_occupancy;
        got.is_full       = out_is_full;
        got.is_empty      = out_is_empty;
        if (predicted_results.size() == 0) begin
          report_mismatch("result with none outstanding", '0, got);
        end else begin
          want = predicted_results.pop_front();
          if (got.removed_value !== want.removed_value ||
              got.removed_valid !== want.removed_valid ||
              got.rejected      !== want.rejected      ||
              got.occupancy     !== want.occupancy     ||
              got.is_full       !== want.is_full       ||
              got.is_empty      !== want.is_empty) begin
            report_mismatch("result mismatch", want, got);
          end
        end
      end
      if (in_valid && !in_stall) begin
        predicted_results.push_back(queue_step(in_func, in_value));
      end
    end
    results_owed <= predicted_results.size();
  end

endmodule

[test/tb_array_priority_queue_max_core.sv]
// Testbench top for the array max-priority queue: stimulus, flow control and verdict.
module tb_array_priority_queue_max_core;
  import apq_pkg::*;

  localparam int DEPTH        = 8;
  localparam int CntW         = $clog2(DEPTH + 1);
  localparam int RANDOM_ITEMS = 1080;
  localparam int HOLD_AT      = 3000;
  localparam int HOLD_LEN     = 400;
  localparam int RX_QUIET_LO  = 1000;
  localparam int RX_QUIET_HI  = 2500;
  localparam int TX_QUIET_LO  = 600;
  localparam int TX_QUIET_HI  = 800;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     in_func = FUNC_INSERT;
  logic signed [DATA_W-1:0] in_value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] out_removed_value;
  logic                     out_removed_valid;
  logic                     out_rejected;
  logic [CntW-1:0]          out_occupancy;
  logic                     out_is_full;
  logic                     out_is_empty;
  int                       fail_count;
  int                       results_owed;
  int                       items_sent = 0;
  int                       rx_cycles = 0;

  array_priority_queue_max_core #(.DEPTH(DEPTH)) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_removed_value(out_removed_value),
    .out_removed_valid(out_removed_valid),
    .out_rejected     (out_rejected),
    .out_occupancy    (out_occupancy),
    .out_is_full      (out_is_full),
    .out_is_empty     (out_is_empty)
  );

  apq_checker #(.DEPTH(DEPTH)) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_removed_value(out_removed_value),
    .out_removed_valid(out_removed_valid),
    .out_rejected     (out_rejected),
    .out_occupancy    (out_occupancy),
    .out_is_full      (out_is_full),
    .out_is_empty     (out_is_empty),
    .fail_count       (fail_count),
    .results_owed     (results_owed)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #5000000;
    $display("[array_priority_queue_max_core] ERROR");
    $finish;
  end

  // Result side: random stalls, one long hold-off, one quiet stretch
  always @(posedge clk) begin
    rx_cycles <= rx_cycles + 1;
    if (rx_cycles >= HOLD_AT && rx_cycles < HOLD_AT + HOLD_LEN) begin
      out_stall <= 1'b1;
    end else if (rx_cycles >= RX_QUIET_LO && rx_cycles < RX_QUIET_HI) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 30);
    end
  end

  // Offer one item, hold it until taken, then maybe idle for a while
  task automatic offer_item(input logic func, input logic [DATA_W-1:0] value);
    int gap;
    in_valid <= 1'b1;
    in_func  <= func;
    in_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (!(items_sent >= TX_QUIET_LO && items_sent < TX_QUIET_HI) &&
        $urandom_range(99) < 30) begin
      gap = ($urandom_range(9) == 0) ? $urandom_range(1, 25) : $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Pick a value: full range, small values for ties, the extremes or values next to them, or the last value again
  function automatic logic [DATA_W-1:0] pick_value(logic [DATA_W-1:0] last_value);
    int sel;
    sel = $urandom_range(9);
    case (sel)
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return $urandom_range(7) - 4;
      7:          return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      8:          return {$urandom_range(1) ? 1'b1 : 1'b0, {(DATA_W-4){1'b1}},
                          3'($urandom_range(7))};
      default:    return last_value;
    endcase
  endfunction

  initial begin
    logic [DATA_W-1:0] last_value;
    bit                fill_mode;
    int                mode_left;
    logic              func;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: remove when empty, extremes, ties, fill past full, drain past empty
    offer_item(FUNC_REMOVE, 32'hFFFF_FFFF);
    offer_item(FUNC_INSERT, 32'h8000_0000);
    offer_item(FUNC_INSERT, 32'h7FFF_FFFF);
    offer_item(FUNC_INSERT, 32'hFFFF_FFFF);
    offer_item(FUNC_INSERT, 32'h0000_0000);
    offer_item(FUNC_INSERT, 32'd5);
    offer_item(FUNC_INSERT, 32'h7FFF_FFFF);
    offer_item(FUNC_INSERT, 32'd5);
    offer_item(FUNC_INSERT, 32'd1);
    offer_item(FUNC_INSERT, 32'd42);
    repeat (DEPTH) offer_item(FUNC_REMOVE, $urandom);
    offer_item(FUNC_REMOVE, 32'h0000_0000);
    offer_item(FUNC_INSERT, 32'h5555_5555);
    offer_item(FUNC_INSERT, 32'hAAAA_AAAA);
    offer_item(FUNC_REMOVE, 32'h0000_0000);

    // Random: alternate fill-heavy and drain-heavy runs to sweep occupancy
    last_value = 32'd0;
    fill_mode  = 1'b1;
    mode_left  = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (mode_left == 0) begin
        fill_mode = ~fill_mode;
        mode_left = $urandom_range(10, 40);
      end
      mode_left--;
      func = (($urandom_range(99) < 75) == fill_mode) ? FUNC_INSERT : FUNC_REMOVE;
      if (func == FUNC_INSERT) begin
        last_value = pick_value(last_value);
        offer_item(FUNC_INSERT, last_value);
      end else begin
        offer_item(FUNC_REMOVE, $urandom);
      end
    end
    in_valid <= 1'b0;

    // Drain: wait for every outstanding result, then let the block settle
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (fail_count == 0 && results_owed == 0) begin
      $display("[array_priority_queue_max_core] OK");
    end else begin
      $display("[array_priority_queue_max_core] ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
design/apq_pkg.sv
design/apq_ctrl.sv
design/apq_datapath.sv
design/array_priority_queue_max_core.sv
test/apq_checker.sv
test/tb_array_priority_queue_max_core.sv
